>>> src/pdve_pkg.sv
// Shared types and constants for the postings delta/varint encoder.
package pdve_pkg;

	localparam int unsigned FIELD_W     = 31;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		MODE_TERM_START = 2'd0,
		MODE_DOC        = 2'd1,
		MODE_POSITION   = 2'd2,
		MODE_TERM_END   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SEL_FREQ    = 2'd0,
		SEL_PROX    = 2'd1,
		SEL_SUMMARY = 2'd2,
		SEL_UNUSED  = 2'd3
	} stream_t;

	typedef enum logic [1:0] {
		JOB_FREQ    = 2'd0,
		JOB_PROX    = 2'd1,
		JOB_ERROR   = 2'd2,
		JOB_SUMMARY = 2'd3
	} job_kind_t;

	typedef struct packed {
		mode_t              mode;
		logic [FIELD_W-1:0] segment_base;
		logic [FIELD_W-1:0] local_doc;
		logic [FIELD_W-1:0] term_freq;
		logic [FIELD_W-1:0] word_position;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		stream_t            stream_sel;
		logic [FIELD_W-1:0] doc_count;
		logic               order_error;
		logic               last_of_run;
	} result_t;

	// One queued job: up to two varints, or a summary/error word.
	// For a summary the count rides in val_b.
	typedef struct packed {
		job_kind_t        kind;
		logic [VAL_W-1:0] val_a;
		logic [VAL_W-1:0] val_b;
		logic             has_b;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage

>>> src/pdve_front.sv
// Front end: takes items, keeps term state, turns each item but a term start into a job.
module pdve_front import pdve_pkg::*; #(
	parameter int unsigned DOC_BITS = 31
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  item_t  item,
	input  logic   q_full,
	output q_ctl_t q_ctl,
	output job_t   job
);

	logic [DOC_BITS-1:0] prev_doc_q;
	logic [FIELD_W-1:0]  prev_pos_q;
	logic [FIELD_W-1:0]  docs_q;

	logic                accept;
	logic [FIELD_W:0]    doc_sum;
	logic [DOC_BITS-1:0] doc;
	logic [DOC_BITS-1:0] delta;
	logic [DOC_BITS:0]   code;
	logic                freq_one;
	logic                backwards;
	logic [VAL_W-1:0]    pos_gap;

	assign accept    = item_valid && !q_full;
	assign item_stall = q_full;

	assign doc_sum   = {1'b0, item.segment_base} + {1'b0, item.local_doc};
	assign doc       = doc_sum[DOC_BITS-1:0];
	assign backwards = doc < prev_doc_q;
	assign delta     = doc - prev_doc_q;
	assign freq_one  = item.term_freq == FIELD_W'(1);
	assign code      = {delta, freq_one};
	assign pos_gap   = {1'b0, item.word_position} - {1'b0, prev_pos_q};

	always_comb begin
		job        = '0;
		q_ctl.full = q_full;
		q_ctl.push = accept && (item.mode != MODE_TERM_START);
		unique case (item.mode)
			MODE_DOC: begin
				if (backwards) begin
					job.kind = JOB_ERROR;
				end else begin
					job.kind  = JOB_FREQ;
					job.val_a = VAL_W'(code);
					job.val_b = {1'b0, item.term_freq};
					job.has_b = !freq_one;
				end
			end
			MODE_POSITION: begin
				job.kind  = JOB_PROX;
				job.val_a = pos_gap;
			end
			MODE_TERM_END: begin
				job.kind  = JOB_SUMMARY;
				job.val_b = {1'b0, docs_q};
			end
			default: begin
				job.kind = JOB_SUMMARY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_doc_q <= '0;
			prev_pos_q <= '0;
			docs_q     <= '0;
		end else if (accept) begin
			case (item.mode)
				MODE_TERM_START: begin
					prev_doc_q <= '0;
					prev_pos_q <= '0;
					docs_q     <= '0;
				end
				MODE_DOC: begin
					if (!backwards) begin
						prev_doc_q <= doc;
						prev_pos_q <= '0;
						if (docs_q != '1) begin
							docs_q <= docs_q + 1'b1;
						end
					end
				end
				MODE_POSITION: begin
					prev_pos_q <= item.word_position;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/pdve_fifo.sv
// Short job queue between the front end and the byte serializer.
module pdve_fifo import pdve_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  q_ctl_t q_ctl,
	input  job_t   wr_job,
	output logic   full,
	input  logic   pop,
	output logic   rd_valid,
	output job_t   rd_job
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_push  = q_ctl.push && !q_ctl.full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

>>> src/pdve_back.sv
// Back end: serializes jobs as varint bytes, a word per unstalled cycle.
module pdve_back import pdve_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic             busy_q;
	job_kind_t        kind_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] second_q;
	logic             has_b_q;

	logic             out_ready;
	logic             advance;
	logic             finish;
	logic             done;
	logic [VAL_W-1:0] rest;
	logic             more;
	result_t          word;

	assign out_ready = !result_valid || !result_stall;
	assign advance   = busy_q && out_ready;
	assign rest      = val_q >> 7;
	assign more      = rest != '0;
	assign done      = advance && finish;
	assign pop       = job_valid && (!busy_q || done);

	always_comb begin
		word   = '0;
		finish = 1'b1;
		unique case (kind_q)
			JOB_ERROR: begin
				word.order_error = 1'b1;
				word.stream_sel  = SEL_FREQ;
				word.last_of_run = 1'b1;
			end
			JOB_SUMMARY: begin
				word.stream_sel  = SEL_SUMMARY;
				word.doc_count   = second_q[FIELD_W-1:0];
				word.last_of_run = 1'b1;
			end
			JOB_FREQ, JOB_PROX: begin
				word.stream_sel  = (kind_q == JOB_PROX) ? SEL_PROX : SEL_FREQ;
				word.out_byte    = {more, val_q[6:0]};
				finish           = !more && !has_b_q;
				word.last_of_run = finish;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (out_ready) begin
				result_valid <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= job.kind;
			val_q    <= job.val_a;
			second_q <= job.val_b;
			has_b_q  <= job.has_b;
		end else if (advance) begin
			if (more) begin
				val_q <= rest;
			end else if (has_b_q) begin
				// first varint done, move on to the frequency
				val_q   <= second_q;
				has_b_q <= 1'b0;
			end
		end
		if (advance) begin
			result <= word;
		end
	end

endmodule

>>> src/postings_delta_varint_encoder.sv
// Top level of the postings delta/varint encoder.
//
// Input channel (item_valid/item_stall/item): one word per term start,
// document, position or term end. Output channel (result_valid/
// result_stall/result): one word per varint byte, order error or term
// summary; last_of_run marks the final word of each input.
// A document word gives its doc-gap code as a varint on the frequency
// stream, followed by a frequency varint unless the frequency is 1.
// A term start produces no output word.
// The first output word of an item passes through the job queue, the
// serializer's job registers and the output register, later if the queue holds earlier work.
// Throughput: the byte serializer emits one word per cycle while the receiver
// does not stall; an item yields 1 to 10 words, and a term start takes an
// input word and yields nothing downstream. The front end takes a word every
// cycle while the two-entry job queue has room.
// Reset clears the term state, the queue and the output valid flag.
// A stalled receiver holds the output word; the serializer then stops,
// the queue fills and item_stall rises.
module postings_delta_varint_encoder import pdve_pkg::*; #(
	parameter int unsigned DOC_BITS = 31
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	q_ctl_t q_ctl;
	job_t   fr_job;
	job_t   bk_job;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;

	pdve_front #(
		.DOC_BITS(DOC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.q_full    (q_full),
		.q_ctl     (q_ctl),
		.job       (fr_job)
	);

	pdve_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_ctl   (q_ctl),
		.wr_job  (fr_job),
		.full    (q_full),
		.pop     (q_pop),
		.rd_valid(q_valid),
		.rd_job  (bk_job)
	);

	pdve_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job         (bk_job),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.push |-> !q_full)
		else $error("job pushed into full queue");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.order_error |->
			result.last_of_run && result.stream_sel == SEL_FREQ && result.out_byte == 8'd0)
		else $error("malformed order-error word");

	a_summary_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stream_sel == SEL_SUMMARY |->
			result.last_of_run && result.out_byte == 8'd0 && !result.order_error)
		else $error("malformed summary word");

	a_continuation: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stream_sel != SEL_SUMMARY && !result.order_error &&
			result.out_byte[7] |-> !result.last_of_run)
		else $error("run ends on a continued varint byte");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the postings delta/varint encoder.
module tb_top;
	import pdve_pkg::*;

	localparam logic [FIELD_W-1:0] FMAX = '1;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 40;

	typedef struct {
		item_t   w;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// encoder state as predicted
	logic [FIELD_W-1:0] last_doc = '0;
	logic [FIELD_W-1:0] last_pos = '0;
	logic [FIELD_W-1:0] doc_tally = '0;

	result_t     pending_words[$];
	dir_row_t    dir_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned words_taken = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;

	postings_delta_varint_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void append_word(ref result_t q[$], input result_t r);
		q.insert(q.size(), r);
	endfunction

	function automatic void append_row(input dir_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_varint(input logic [31:0] v, input stream_t s,
			ref result_t outs[$]);
		result_t r;
		do begin
			r = '0;
			r.stream_sel = s;
			r.out_byte = {1'b0, v[6:0]};
			v = v >> 7;
			r.out_byte[7] = (v != 0);
			append_word(outs, r);
		end while (v != 0);
	endfunction

	// Expected output words for one input word; advances the predicted state.
	function automatic void encode_item(input item_t w, ref result_t outs[$]);
		logic [31:0]        sum;
		logic [31:0]        code;
		logic [31:0]        gap;
		logic [FIELD_W-1:0] doc_num;
		case (w.mode)
			MODE_TERM_START: begin
				last_doc = '0;
				last_pos = '0;
				doc_tally = '0;
			end
			MODE_DOC: begin
				sum = {1'b0, w.segment_base} + {1'b0, w.local_doc};
				doc_num = sum[FIELD_W-1:0];  // wraps at 2^31
				if (doc_num < last_doc) begin
					append_word(outs, '{8'h00, SEL_FREQ, 31'd0, 1'b1, 1'b0});
				end else begin
					code = {1'b0, doc_num - last_doc} << 1;
					last_doc = doc_num;
					if (w.term_freq == 31'd1) begin
						add_varint(code | 32'd1, SEL_FREQ, outs);
					end else begin
						add_varint(code, SEL_FREQ, outs);
						add_varint({1'b0, w.term_freq}, SEL_FREQ, outs);
					end
					last_pos = '0;
					if (doc_tally != FMAX)
						doc_tally++;
				end
			end
			MODE_POSITION: begin
				gap = {1'b0, w.word_position} - {1'b0, last_pos};
				last_pos = w.word_position;
				add_varint(gap, SEL_PROX, outs);
			end
			default: begin
				append_word(outs, '{8'h00, SEL_SUMMARY, doc_tally, 1'b0, 1'b0});
			end
		endcase
		if (outs.size() != 0)
			outs[outs.size()-1].last_of_run = 1'b1;
	endfunction

	// Offer one word, wait for it to be taken, then queue what it should yield.
	task automatic offer(input item_t w, input bit typed, input result_t want);
		result_t outs[$];
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_taken++;
		encode_item(w, outs);
		if (typed)
			append_word(pending_words, want);
		else
			foreach (outs[i])
				append_word(pending_words, outs[i]);
	endtask

	function automatic item_t noise_item();
		item_t w;
		w.mode = mode_t'($urandom_range(3));
		w.segment_base = FIELD_W'($urandom);
		w.local_doc = FIELD_W'($urandom);
		w.term_freq = FIELD_W'($urandom);
		w.word_position = FIELD_W'($urandom);
		return w;
	endfunction

	// One term: start, documents with positions, the odd stray or backwards
	// document, then the term end.
	task automatic gen_term();
		item_t       w;
		longint      tgt;
		logic [31:0] gap;
		logic [31:0] base;
		int unsigned n_docs;
		int unsigned n_pos;
		int unsigned pick;
		w = noise_item();
		w.mode = MODE_TERM_START;
		offer(w, 1'b0, '0);
		n_docs = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
		repeat (n_docs) begin
			if ($urandom_range(11) == 0)
				offer(noise_item(), 1'b0, '0);
			w = noise_item();
			w.mode = MODE_DOC;
			if (last_doc != 0 && $urandom_range(14) == 0) begin
				tgt = longint'($urandom_range(last_doc - 1, 0));
			end else begin
				pick = $urandom_range(9);
				if (pick < 8)
					gap = $urandom_range(100, 1);
				else if (pick == 8)
					gap = $urandom_range(20000, 0);
				else
					gap = $urandom & 32'h7FFF_FFFF;
				tgt = longint'(last_doc) + longint'(gap);
				if (tgt > longint'(FMAX))
					tgt = longint'(FMAX);
			end
			// random base, local picked so the sum lands on the target
			base = $urandom;
			w.segment_base = base[FIELD_W-1:0];
			w.local_doc = tgt[FIELD_W-1:0] - base[FIELD_W-1:0];
			pick = $urandom_range(19);
			if (pick < 10)
				w.term_freq = 31'd1;
			else if (pick < 17)
				w.term_freq = FIELD_W'($urandom_range(6, 2));
			else if (pick < 19)
				w.term_freq = FIELD_W'($urandom);
			else
				w.term_freq = 31'd0;
			offer(w, 1'b0, '0);
			n_pos = $urandom_range(4);
			repeat (n_pos) begin
				w = noise_item();
				w.mode = MODE_POSITION;
				if ($urandom_range(9) != 0)
					w.word_position = last_pos + FIELD_W'($urandom_range(50, 1));
				offer(w, 1'b0, '0);
			end
		end
		w = noise_item();
		w.mode = MODE_TERM_END;
		offer(w, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin : check_output
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				$error("output word with nothing expected: %p", result);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
					mismatch_count++;
				end
				if (result.stream_sel !== want.stream_sel) begin
					$error("stream_sel: expected %0d, got %0d",
						want.stream_sel, result.stream_sel);
					mismatch_count++;
				end
				if (result.doc_count !== want.doc_count) begin
					$error("doc_count: expected %0d, got %0d",
						want.doc_count, result.doc_count);
					mismatch_count++;
				end
				if (result.order_error !== want.order_error) begin
					$error("order_error: expected %0b, got %0b",
						want.order_error, result.order_error);
					mismatch_count++;
				end
				if (result.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b",
						want.last_of_run, result.last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned start_count;
		append_row('{'{MODE_TERM_END, 31'd0, 31'd0, 31'd1, 31'd0}, 1'b1,
			'{8'h00, SEL_SUMMARY, 31'd0, 1'b0, 1'b1}});
		append_row('{'{MODE_TERM_START, FMAX, FMAX, FMAX, FMAX}, 1'b0, '0});
		append_row('{'{MODE_DOC, 31'd0, 31'd0, 31'd1, FMAX}, 1'b1,
			'{8'h01, SEL_FREQ, 31'd0, 1'b0, 1'b1}});
		append_row('{'{MODE_DOC, 31'd5, 31'd3, 31'd0, 31'd0}, 1'b0, '0});
		// backwards document
		append_row('{'{MODE_DOC, 31'd0, 31'd7, 31'd1, 31'd0}, 1'b1,
			'{8'h00, SEL_FREQ, 31'd0, 1'b1, 1'b1}});
		append_row('{'{MODE_POSITION, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b1,
			'{8'h00, SEL_PROX, 31'd0, 1'b0, 1'b1}});
		append_row('{'{MODE_POSITION, 31'd0, 31'd0, 31'd0, 31'd200}, 1'b0, '0});
		// position going back wraps into a five-byte gap
		append_row('{'{MODE_POSITION, 31'd0, 31'd0, 31'd0, 31'd3}, 1'b0, '0});
		append_row('{'{MODE_POSITION, 31'd0, 31'd0, 31'd0, FMAX}, 1'b0, '0});
		append_row('{'{MODE_DOC, FMAX, FMAX, FMAX, 31'd0}, 1'b0, '0});
		// sum wraps to zero, so this one goes backwards too
		append_row('{'{MODE_DOC, FMAX, 31'd1, 31'd1, 31'd0}, 1'b1,
			'{8'h00, SEL_FREQ, 31'd0, 1'b1, 1'b1}});
		append_row('{'{MODE_TERM_END, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b0, '0});
		append_row('{'{MODE_TERM_START, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b0, '0});
		append_row('{'{MODE_DOC, FMAX, 31'd0, 31'd2, 31'd0}, 1'b0, '0});
		append_row('{'{MODE_POSITION, 31'd0, 31'd0, 31'd0, FMAX}, 1'b0, '0});
		append_row('{'{MODE_POSITION, FMAX, FMAX, FMAX, 31'd0}, 1'b0, '0});
		// same document again: zero gap, frequency one
		append_row('{'{MODE_DOC, 31'd0, FMAX, 31'd1, 31'd0}, 1'b1,
			'{8'h01, SEL_FREQ, 31'd0, 1'b0, 1'b1}});
		append_row('{'{MODE_TERM_END, FMAX, FMAX, FMAX, FMAX}, 1'b0, '0});
		append_row('{'{MODE_TERM_START, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b0, '0});
		append_row('{'{MODE_TERM_END, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b1,
			'{8'h00, SEL_SUMMARY, 31'd0, 1'b0, 1'b1}});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 33;
		recv_idle = 51;
		foreach (dir_rows[i])
			offer(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
		start_count = words_taken;
		while (words_taken < start_count + ITEMS_PER_PHASE)
			gen_term();

		send_idle = 51;
		recv_idle = 33;
		while (words_taken < start_count + 2 * ITEMS_PER_PHASE)
			gen_term();

		// long receiver hold-off while words keep coming, to back up the queue
		send_idle = 0;
		recv_idle = 0;
		hold_req <= ~hold_req;
		while (words_taken < start_count + 3 * ITEMS_PER_PHASE)
			gen_term();

		item_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
src/pdve_pkg.sv
src/pdve_front.sv
src/pdve_fifo.sv
src/pdve_back.sv
src/postings_delta_varint_encoder.sv
verif/tb_top.sv
